>>> design/tdam_pkg.sv
// Shared types and constants for the threshold / dilate alpha-mask block.
// Request and result payload structs, register and operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdam_pkg;

	// Default build parameters
	localparam int DEF_MAX_WIDTH = 512;
	localparam int DEF_RADIUS    = 2;

	// Register file
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [7:0] THRESHOLD_RESET = 8'd20;
	localparam logic [9:0] WIDTH_RESET     = 10'd128;
	localparam logic [9:0] HEIGHT_RESET    = 10'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WIDTH     = 2'd1,
		CFG_HEIGHT    = 2'd2
	} cfg_index_t;

	// Row counter: frame height (10 bits) plus the radius overhang of the drain rows
	localparam int ROW_W = 11;

	// Request commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Alpha levels
	localparam logic [7:0] ALPHA_ON  = 8'd255;
	localparam logic [7:0] ALPHA_OFF = 8'd0;

	// Operation carried through the line-store stage
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,  // pixel: read column, insert mask bit, write back
		OP_READ  = 2'd1,  // drain: read column only
		OP_SHIFT = 2'd2   // right edge: shift an empty column into the window
	} op_kind_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

>>> design/threshold_dilate_alpha_mask_top.sv
// Threshold + square dilation alpha mask over a raster pixel stream.
// A result is offered after its request or internal step passes s1 into the result queue.
// Throughput: one request per cycle unless stalled; each output row takes width + RADIUS
// steps, the RADIUS extra steps being right-edge window shifts (row end) or left-edge
// pre-reads (drain rows). Reset: counters, window control and result queue cleared,
// registers to their reset values; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module threshold_dilate_alpha_mask_top
	import tdam_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int RADIUS    = DEF_RADIUS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	// result channel
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	// register write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Window rows / columns, line-store word width
	localparam int W  = 2 * RADIUS + 1;
	localparam int YW = $clog2(W);
	// column step index runs to width - 1 + RADIUS
	localparam int CW = $clog2(MAX_WIDTH + RADIUS + 1);
	localparam int AW = $clog2(MAX_WIDTH);
	// result queue
	localparam int RES_DEPTH = 4;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 2);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	logic [7:0] thr_q;
	logic [9:0] fw_q;
	logic [9:0] fh_q;
	logic       restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			fw_q  <= WIDTH_RESET;
			fh_q  <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_THRESHOLD: thr_q <= cfg_data[7:0];
				CFG_WIDTH:     fw_q  <= cfg_data[9:0];
				CFG_HEIGHT:    fh_q  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// a size write starts a fresh frame
	assign restart = cfg_we &&
		(cfg_index_t'(cfg_index) == CFG_WIDTH || cfg_index_t'(cfg_index) == CFG_HEIGHT);

	// clipped frame size
	logic [CW-1:0]    weff;
	logic [ROW_W-1:0] heff;

	always_comb begin
		if (fw_q == '0) begin
			weff = CW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			weff = CW'(MAX_WIDTH);
		end else begin
			weff = CW'(fw_q);
		end
		heff = (fh_q == '0) ? ROW_W'(1) : ROW_W'(fh_q);
	end

	// ------------------------------------------------------------------
	// Step sequencer (s0)
	// Every output row is walked as width + RADIUS steps: columns 0..width-1 read the
	// line store, the last RADIUS steps shift empty columns in at the right
	// edge. Step j emits column j - RADIUS once j >= RADIUS. After the last
	// input row, virtual rows height..height-1+RADIUS release the bottom rows,
	// one step per drain request; their leading RADIUS steps run on their own.
	// ------------------------------------------------------------------
	logic [ROW_W-1:0] row_q, row_d;
	logic [CW-1:0]    col_q, col_d;
	logic [YW-1:0]    ymod_q, ymod_d;   // row_q mod W: line-store slot of this row

	logic             drain_ph, has_out, auto_need, fifo_ok, emit_pend;
	logic             item_acc, item_useful, op_fire, op_emit, op_last, op_reads;
	logic             bright;
	op_kind_t         op_kind;
	logic [CW-1:0]    row_end_col;
	logic [ROW_W-1:0] last_row;
	logic [YW-1:0]    ymod_inc;
	logic [W-1:0]     op_mask;
	logic             fwd_hit;

	// result queue state used by the sequencer
	logic [CNT_W-1:0] cnt_q;

	// s1 state used by the sequencer
	logic             vld_s1;
	op_kind_t         kind_s1;
	logic [AW-1:0]    addr_s1;
	logic             emit_s1;
	logic [W-1:0]     wr_word;

	always_comb begin
		drain_ph  = row_q >= heff;
		has_out   = row_q >= ROW_W'(RADIUS);
		auto_need = drain_ph ? (col_q < CW'(RADIUS)) : (col_q >= weff);
		emit_pend = vld_s1 && emit_s1;
		// room for this step's result even if nothing leaves the queue
		fifo_ok   = (cnt_q + CNT_W'(emit_pend)) < CNT_W'(RES_DEPTH);

		item_stall  = !fifo_ok || auto_need;
		item_acc    = item_valid && !item_stall;
		// pixels while draining and drains mid-frame are swallowed
		item_useful = drain_ph ? (item.cmd == CMD_DRAIN) : (item.cmd == CMD_PIXEL);
		op_fire     = (auto_need && fifo_ok) || (item_acc && item_useful);

		if (drain_ph) begin
			op_kind = (col_q < weff) ? OP_READ : OP_SHIFT;
		end else begin
			op_kind = auto_need ? OP_SHIFT : OP_WRITE;
		end
		op_reads = op_kind != OP_SHIFT;

		bright = (item.red > thr_q) || (item.green > thr_q) || (item.blue > thr_q);

		// rows with no output skip the right-edge shifts
		row_end_col = (!drain_ph && !has_out) ? weff - CW'(1)
		                                      : weff - CW'(1) + CW'(RADIUS);
		last_row = heff - ROW_W'(1) + ROW_W'(RADIUS);
		op_emit  = has_out && (col_q >= CW'(RADIUS));
		op_last  = (row_q == last_row) && (col_q == row_end_col);
		ymod_inc = (ymod_q == YW'(W - 1)) ? '0 : ymod_q + YW'(1);

		// same column written by the step ahead of this one
		fwd_hit = vld_s1 && (kind_s1 == OP_WRITE) && (addr_s1 == col_q[AW-1:0]) && op_reads;
	end

	// slot mask for the window centred on row_q - RADIUS, clipped to the frame
	always_comb begin
		logic [YW-1:0] k;
		for (int s = 0; s < W; s++) begin
			if (ymod_q >= YW'(s)) begin
				k = ymod_q - YW'(s);
			end else begin
				k = ymod_q + YW'(W - s);
			end
			// slot holds row row_q - k: in frame and not above the top
			op_mask[s] = (ROW_W'(k) <= row_q) && (row_q <= heff - ROW_W'(1) + ROW_W'(k));
		end
	end

	always_comb begin
		row_d  = row_q;
		col_d  = col_q;
		ymod_d = ymod_q;
		if (restart) begin
			row_d  = '0;
			col_d  = '0;
			ymod_d = '0;
		end else if (op_fire) begin
			if (col_q == row_end_col) begin
				col_d = '0;
				if (op_last) begin
					row_d  = '0;
					ymod_d = '0;
				end else if (!drain_ph && (row_q + ROW_W'(1) == heff) &&
				             (heff < ROW_W'(RADIUS))) begin
					// very short frame: drain rows start at RADIUS
					row_d  = ROW_W'(RADIUS);
					ymod_d = YW'(RADIUS);
				end else begin
					row_d  = row_q + ROW_W'(1);
					ymod_d = ymod_inc;
				end
			end else begin
				col_d = col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			ymod_q <= '0;
		end else begin
			row_q  <= row_d;
			col_q  <= col_d;
			ymod_q <= ymod_d;
		end
	end

	// ------------------------------------------------------------------
	// Line store: one word per column, one bit per buffered row
	// ------------------------------------------------------------------
	logic [W-1:0] rd_data;
	logic         ram_we;

	tdam_ram #(
		.WIDTH (W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s1),
		.wdata (wr_word),
		.re    (op_fire && op_reads),
		.raddr (col_q[AW-1:0]),
		.rdata (rd_data)
	);

	// ------------------------------------------------------------------
	// s1: read-modify-write, column OR, horizontal window
	// ------------------------------------------------------------------
	logic          bright_s1, first_s1, last_s1, fwd_s1;
	logic [W-1:0]  mask_s1, fwdw_s1;
	logic [YW-1:0] ymod_s1;
	logic [W-1:0]  win_q, win_next, word_s1;
	logic          col_or, push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (op_fire) begin
			kind_s1   <= op_kind;
			addr_s1   <= col_q[AW-1:0];
			bright_s1 <= bright;
			first_s1  <= col_q == '0;
			emit_s1   <= op_emit;
			last_s1   <= op_last;
			mask_s1   <= op_mask;
			ymod_s1   <= ymod_q;
			fwd_s1    <= fwd_hit;
			fwdw_s1   <= wr_word;
		end
	end

	always_comb begin
		word_s1 = fwd_s1 ? fwdw_s1 : rd_data;
		wr_word = word_s1;
		if (kind_s1 == OP_WRITE) begin
			wr_word[ymod_s1] = bright_s1;
		end
		col_or   = (kind_s1 != OP_SHIFT) && (|(wr_word & mask_s1));
		// left of column 0 counts as empty
		win_next = first_s1 ? {{(W - 1){1'b0}}, col_or} : {win_q[W-2:0], col_or};
		ram_we   = vld_s1 && (kind_s1 == OP_WRITE);
		push     = vld_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			win_q <= win_next;
		end
	end

	// ------------------------------------------------------------------
	// Result queue
	// ------------------------------------------------------------------
	result_t          res_mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic             pop;

	assign result_valid = cnt_q != '0;
	assign result       = res_mem_q[rd_ptr_q];
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			res_mem_q[wr_ptr_q] <= '{alpha: (|win_next) ? ALPHA_ON : ALPHA_OFF,
			                         last:  last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// the credit check keeps a slot free for every result in flight
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < CNT_W'(RES_DEPTH)) || pop)
		else $error("result queue overflow");

	// the frame's final result leaves the sequencer back at the top
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		push && last_s1 |-> (row_q == '0) && (col_q == CW'(0) || col_q == CW'(1)))
		else $error("sequencer not restarted after final result");

	// line-store writes stay inside the frame width
	a_write_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(addr_s1) < weff) && $past(!drain_ph))
		else $error("line store write outside frame");

endmodule

`default_nettype wire

>>> design/tdam_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the column line store; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tdam_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for threshold_dilate_alpha_mask_top: directed table, then random frames.
// Expected alpha results come from a behavioural model of threshold plus dilation held here.
// Depends on tdam_pkg and the block's RTL; reads no files.
`timescale 1ns / 1ps

module tb;
	import tdam_pkg::*;

	localparam int RADIUS          = DEF_RADIUS;
	localparam int MAX_W           = DEF_MAX_WIDTH;
	localparam int WINDOW_ROWS     = 2 * RADIUS + 1;
	localparam int RANDOM_REQUESTS = 400;
	localparam int IDLE_CYCLES     = 16;   // covers latency plus the right-edge shift steps
	localparam int TAIL_CYCLES     = 20;
	localparam int LONG_HOLD       = 300;  // receiver hold-off, long enough to back up the input
	localparam int NUM_DIRECTED    = 32;
	localparam int LARGE_PIXELS    = 24;   // pixels sent into each of the largest frames
	localparam int unsigned FULL_FRAME = 32'hFFFF_FFFF;

	// Directed table rows: a register write, a request checked by the model,
	// or a request whose single result is typed into the row.
	typedef enum logic [1:0] {
		ROW_REG,
		ROW_REQ,
		ROW_CHECKED
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		cfg_index_t idx;
		logic [9:0] value;
		item_t      req;
		result_t    want;
	} step_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	item_t            item;
	logic             result_valid;
	logic             result_stall;
	result_t          result;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [9:0]       cfg_data;

	// Model state: mask bits of the last rows, raster position, drain progress, registers
	logic             mask_rows [WINDOW_ROWS][MAX_W];
	int unsigned      col_at;
	int unsigned      row_at;
	int unsigned      drained;
	logic [7:0]       thr_reg;
	logic [9:0]       width_reg;
	logic [9:0]       height_reg;

	result_t          fresh [$];          // results of the request just predicted
	result_t          alpha_expected [$]; // results still owed by the block

	int               mismatches;
	int               requests_sent;
	int               effective_count;
	int               results_checked;
	int               settings_used;
	bit               steady;             // sender offers back to back during this phase
	bit               long_hold_done;
	step_t            directed [NUM_DIRECTED];

	threshold_dilate_alpha_mask_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Model of the block
	// ---------------------------------------------------------------

	// Out-of-range sizes are clamped: width 0 acts as 1, wider than the
	// line store acts as its full width; height 0 acts as 1.
	function automatic int unsigned frame_w();
		if (width_reg == 10'd0) return 1;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned frame_h();
		return (height_reg == 10'd0) ? 1 : height_reg;
	endfunction

	function automatic void restart_frame();
		col_at = 0;
		row_at = 0;
		drained = 0;
	endfunction

	function automatic void apply_reg(input cfg_index_t idx, input logic [9:0] value);
		case (idx)
			CFG_THRESHOLD: begin
				thr_reg = value[7:0];
			end
			CFG_WIDTH: begin
				width_reg = value;
				restart_frame();
			end
			CFG_HEIGHT: begin
				height_reg = value;
				restart_frame();
			end
			default: begin
			end
		endcase
	endfunction

	// Alpha of one output pixel: any bright pixel within the clipped square
	function automatic result_t pixel_result(input int unsigned r, input int unsigned c,
			input int unsigned w, input int unsigned h);
		int unsigned r0, r1, c0, c1, rr, cc;
		result_t res;
		r0 = (r >= RADIUS) ? r - RADIUS : 0;
		r1 = (r + RADIUS < h) ? r + RADIUS : h - 1;
		c0 = (c >= RADIUS) ? c - RADIUS : 0;
		c1 = (c + RADIUS < w) ? c + RADIUS : w - 1;
		res.alpha = ALPHA_OFF;
		for (rr = r0; rr <= r1; rr++)
			for (cc = c0; cc <= c1; cc++)
				if (mask_rows[rr % WINDOW_ROWS][cc]) res.alpha = ALPHA_ON;
		res.last = (r == h - 1) && (c == w - 1);
		return res;
	endfunction

	// Advances the model by one request; fills fresh and returns 0 if the
	// block is to ignore the request.
	function automatic bit predict_request(input item_t req);
		int unsigned w, h, first, total, x, y, c, level;
		w = frame_w();
		h = frame_h();
		fresh.delete();
		if (req.cmd == CMD_DRAIN) begin
			if (row_at < h) return 1'b0;
			first = (h > RADIUS) ? h - RADIUS : 0;
			total = (h - first) * w;
			fresh.push_back(pixel_result(first + drained / w, drained % w, w, h));
			drained++;
			if (drained == total) restart_frame();
			return 1'b1;
		end
		if (row_at >= h) return 1'b0;
		x = col_at;
		y = row_at;
		level = req.red;
		if (req.green > level) level = req.green;
		if (req.blue > level) level = req.blue;
		mask_rows[y % WINDOW_ROWS][x] = (level > thr_reg);
		if (y >= RADIUS) begin
			if (x == w - 1) begin
				for (c = (x >= RADIUS) ? x - RADIUS : 0; c < w; c++)
					fresh.push_back(pixel_result(y - RADIUS, c, w, h));
			end else if (x >= RADIUS) begin
				fresh.push_back(pixel_result(y - RADIUS, x - RADIUS, w, h));
			end
		end
		if (x + 1 >= w) begin
			col_at = 0;
			row_at = y + 1;
		end else begin
			col_at = x + 1;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic step_t reg_row(input cfg_index_t idx, input logic [9:0] value);
		step_t s;
		s = '0;
		s.kind = ROW_REG;
		s.idx = idx;
		s.value = value;
		return s;
	endfunction

	function automatic step_t req_row(input logic cmd, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		step_t s;
		s = '0;
		s.kind = ROW_REQ;
		s.req = '{cmd: cmd, red: r, green: g, blue: b};
		return s;
	endfunction

	// Drain on a 1x1 frame: one result, always the last pixel
	function automatic step_t drain_row(input logic [7:0] alpha);
		step_t s;
		s = req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
		s.kind = ROW_CHECKED;
		s.want = '{alpha: alpha, last: 1'b1};
		return s;
	endfunction

	// Mostly no gap, some short gaps, now and then a long one
	function automatic int unsigned gap_cycles();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 60) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Dark pixels mostly, a few bright, a few with fully random colour
	function automatic item_t pixel_request();
		item_t req;
		int unsigned pick;
		pick = $urandom_range(0, 29);
		req.cmd = CMD_PIXEL;
		req.red = 8'($urandom_range(0, thr_reg));
		req.green = 8'($urandom_range(0, thr_reg));
		req.blue = 8'($urandom_range(0, thr_reg));
		if (pick < 2) begin
			req.red = 8'($urandom);
			req.green = 8'($urandom);
			req.blue = 8'($urandom);
		end else if (pick < 4 && thr_reg != 8'hFF) begin
			case ($urandom_range(0, 2))
				0: req.red = 8'($urandom_range(int'(thr_reg) + 1, 255));
				1: req.green = 8'($urandom_range(int'(thr_reg) + 1, 255));
				default: req.blue = 8'($urandom_range(int'(thr_reg) + 1, 255));
			endcase
		end
		return req;
	endfunction

	// Offer one request, hold it until accepted, then book its results.
	// Valid is only lowered when a gap follows, so back-to-back requests
	// never see valid dropped and raised in the same step.
	task automatic send_request(input item_t req, input bit typed, input result_t want);
		int unsigned gap;
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		requests_sent++;
		if (predict_request(req)) effective_count++;
		if (typed) begin
			fresh.delete();
			fresh.push_back(want);
		end
		foreach (fresh[k]) alpha_expected.push_back(fresh[k]);
		gap = gap_cycles();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Block idle: nothing owed, then a margin for steps that give no result
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (alpha_expected.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high so consecutive writes need no toggle
	task automatic write_reg(input cfg_index_t idx, input logic [9:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		apply_reg(idx, value);
	endtask

	task automatic setup_frame(input logic [7:0] thr, input logic [9:0] w, input logic [9:0] h);
		wait_idle();
		write_reg(CFG_THRESHOLD, 10'(thr));
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Raster pixels up to pixel_limit, then drains until the frame restarts.
	// Stray drains mid-frame and stray pixels while draining are sprinkled
	// in; the block must ignore both.
	task automatic run_frame(input int unsigned pixel_limit);
		int unsigned sent;
		item_t extra;
		sent = 0;
		while (row_at < frame_h() && sent < pixel_limit) begin
			if ($urandom_range(0, 39) == 0) begin
				extra = pixel_request();
				extra.cmd = CMD_DRAIN;
				send_request(extra, 1'b0, '0);
			end
			send_request(pixel_request(), 1'b0, '0);
			sent++;
		end
		while (row_at >= frame_h()) begin
			if ($urandom_range(0, 39) == 0) send_request(pixel_request(), 1'b0, '0);
			extra = pixel_request();
			extra.cmd = CMD_DRAIN;
			send_request(extra, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random stalls, one long hold-off, in-order checking
	// ---------------------------------------------------------------
	initial begin
		int unsigned hold_left, stall_left, run_left;
		result_t want;
		hold_left = 0;
		stall_left = 0;
		run_left = 0;
		long_hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (alpha_expected.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got alpha %0d last %0d",
						$time, result.alpha, result.last);
				end else begin
					want = alpha_expected.pop_front();
					results_checked++;
					if (result.alpha !== want.alpha) begin
						mismatches++;
						$display("%0t: alpha mismatch, expected %0d, got %0d",
							$time, want.alpha, result.alpha);
					end
					if (result.last !== want.last) begin
						mismatches++;
						$display("%0t: last mismatch, expected %0d, got %0d",
							$time, want.last, result.last);
					end
				end
			end
			// once, mid-run: hold off long enough for the block to back up
			if (!long_hold_done && results_checked >= 60) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (run_left != 0) begin
				run_left--;
				result_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: run_left = $urandom_range(1, 30);
					5, 6, 7, 8: stall_left = $urandom_range(1, 3);
					default: stall_left = $urandom_range(8, 40);
				endcase
				result_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int random_goal;
		int unsigned pick, mode;
		logic [7:0] next_thr;
		logic [9:0] next_w, next_h;
		item_t noise;

		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_THRESHOLD;
		cfg_data = '0;
		mismatches = 0;
		requests_sent = 0;
		effective_count = 0;
		results_checked = 0;
		settings_used = 1;
		steady = 1'b0;
		thr_reg = THRESHOLD_RESET;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		restart_frame();

		// Directed part. 1x1 frames give one result per drain that can be
		// read off directly; a 3x3 frame then exercises the row-end burst.
		directed = '{
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),         // drain before any frame: ignored
			reg_row(CFG_WIDTH, 10'd0),                     // width 0 acts as 1
			reg_row(CFG_HEIGHT, 10'd0),                    // height 0 acts as 1
			req_row(CMD_PIXEL, 8'd21, 8'd0, 8'd0),         // just above reset threshold
			req_row(CMD_PIXEL, 8'd255, 8'd255, 8'd255),    // frame complete: ignored
			drain_row(ALPHA_ON),
			req_row(CMD_DRAIN, 8'd255, 8'd255, 8'd255),    // after the drain ends: ignored
			reg_row(CFG_THRESHOLD, 10'd255),
			req_row(CMD_PIXEL, 8'd255, 8'd255, 8'd255),    // equal to threshold: background
			drain_row(ALPHA_OFF),
			reg_row(CFG_THRESHOLD, 10'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd1),
			drain_row(ALPHA_ON),
			reg_row(CFG_THRESHOLD, 10'd128),
			reg_row(CFG_WIDTH, 10'd3),
			reg_row(CFG_HEIGHT, 10'd3),
			req_row(CMD_PIXEL, 8'd128, 8'd128, 8'd128),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),         // mid-frame drain: ignored
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd0),
			req_row(CMD_PIXEL, 8'd0, 8'd0, 8'd255),       // row end: three results
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0),
			req_row(CMD_DRAIN, 8'd0, 8'd0, 8'd0)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (directed[i].kind == ROW_REG) begin
				if (i == 0 || directed[i - 1].kind != ROW_REG) wait_idle();
				write_reg(directed[i].idx, directed[i].value);
				settings_used++;
			end else begin
				cfg_we <= 1'b0;
				send_request(directed[i].req, directed[i].kind == ROW_CHECKED, directed[i].want);
			end
		end

		// Random part: one frame setting per phase, mostly small frames.
		// Most phases run a complete frame; some stop part-way, some are
		// pure noise. Size writes restart the frame either way.
		random_goal = effective_count + RANDOM_REQUESTS;
		while (effective_count < random_goal) begin
			steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 7);
			next_thr = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom);
			pick = $urandom_range(0, 19);
			next_w = (pick == 0) ? 10'd0 :
				(pick == 1) ? 10'($urandom_range(13, 40)) : 10'($urandom_range(1, 12));
			pick = $urandom_range(0, 11);
			next_h = (pick == 0) ? 10'd0 : 10'($urandom_range(1, 8));
			setup_frame(next_thr, next_w, next_h);
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				run_frame($urandom_range(1, frame_w() * frame_h()));
			end else if (mode == 1) begin
				repeat ($urandom_range(4, 16)) begin
					noise.cmd = 1'($urandom_range(0, 1));
					noise.red = 8'($urandom);
					noise.green = 8'($urandom);
					noise.blue = 8'($urandom);
					send_request(noise, 1'b0, '0);
				end
			end else begin
				run_frame(FULL_FRAME);
			end
		end

		// The largest sizes, briefly: the start of an over-wide frame clamped
		// to the line store, and of the tallest single-column frame. The
		// size writes restart whatever is left of either.
		steady = 1'b0;
		setup_frame(8'($urandom), 10'd1023, 10'd1);
		run_frame(LARGE_PIXELS);
		setup_frame(8'($urandom), 10'd1, 10'd1023);
		run_frame(LARGE_PIXELS);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests (%0d taking effect) across %0d register settings.",
			requests_sent, effective_count, settings_used);
		$display("%0d results checked, %0d mismatches, long receiver hold-off %s.",
			results_checked, mismatches, long_hold_done ? "applied" : "not reached");
		if (mismatches == 0 && alpha_expected.size() == 0) begin
			$display("** threshold_dilate_alpha_mask_top: PASSED **");
		end else begin
			$display("** threshold_dilate_alpha_mask_top: FAILED **");
		end
		$finish;
	end

	// Watchdog, several times the slowest legal run
	initial begin
		#20_000_000;
		$display("** threshold_dilate_alpha_mask_top: FAILED **");
		$finish;
	end

endmodule
